[hdl/assert_macros.svh]
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked each clock, disabled in reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

[hdl/bbcm_pkg.sv]
// Types and constants for the block buffer cache manager.
// No dependencies.
package bbcm_pkg;
    localparam int BUFFER_COUNT = 1024;
    localparam int BUCKET_COUNT = 16;
    localparam int IW = $clog2(BUFFER_COUNT);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int PW = IW + 1;

    localparam logic [1:0] K_GET = 2'd0;
    localparam logic [1:0] K_DONE = 2'd1;
    localparam logic [1:0] K_REL = 2'd2;
    localparam logic [1:0] K_REARM = 2'd3;

    localparam logic [2:0] ST_HIT = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_BUSY = 3'd2;
    localparam logic [2:0] ST_NONE = 3'd3;
    localparam logic [2:0] ST_ACCEPT = 3'd4;
    localparam logic [2:0] ST_ERROR = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  device_id;
        logic [31:0] block_number;
        logic [9:0]  buffer_index;
        logic        io_failed;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] granted_index;
        logic       needs_read;
    } t_out;

    // classified command handed from front to back
    typedef struct packed {
        t_in  req;
        logic idx_ok;
    } t_cmd;
endpackage

[hdl/bbcm_front.sv]
// Front end: accepts request beats, range-checks the index, fills a 2-entry queue.
// Depends on bbcm_pkg.
module bbcm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bbcm_pkg::t_in   i_data,
    output logic            o_cvalid,
    input  logic            i_cready,
    output bbcm_pkg::t_cmd  o_cmd
);
    bbcm_pkg::t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    bbcm_pkg::t_cmd c;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_cvalid = (r_cnt != 2'd0);
    assign pop = o_cvalid && i_cready;
    assign o_cmd = r_q[r_rp];

    always_comb begin
        c.req = i_data;
        c.idx_ok = ({22'd0, i_data.buffer_index} < 32'(bbcm_pkg::BUFFER_COUNT));
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= c;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[hdl/bbcm_back.sv]
// Back end: sequencer over tag, flag, free-list and bucket memories.
// Depends on bbcm_pkg.
module bbcm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cvalid,
    output logic            o_cready,
    input  bbcm_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output bbcm_pkg::t_out  o_data
);
    localparam int IW = bbcm_pkg::IW;
    localparam int PW = bbcm_pkg::PW;
    localparam int BW = bbcm_pkg::BW;
    localparam logic [PW-1:0] NIL = PW'(bbcm_pkg::BUFFER_COUNT);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_FRD, S_FOP, S_WALK, S_WCHK,
        S_HIT, S_RM, S_RM2, S_MISS, S_BR, S_BRC, S_BRN, S_BINS,
        S_OUT
    } t_state;

    logic [7:0]    m_dev  [bbcm_pkg::BUFFER_COUNT];
    logic [31:0]   m_blk  [bbcm_pkg::BUFFER_COUNT];
    logic [4:0]    m_flg  [bbcm_pkg::BUFFER_COUNT];
    logic [IW-1:0] m_fn   [bbcm_pkg::BUFFER_COUNT];
    logic [IW-1:0] m_fp   [bbcm_pkg::BUFFER_COUNT];
    logic [PW-1:0] m_bn   [bbcm_pkg::BUFFER_COUNT];
    logic [PW-1:0] r_bh   [bbcm_pkg::BUCKET_COUNT];

    t_state r_st;
    bbcm_pkg::t_cmd r_cmd;
    logic [IW-1:0] r_head, r_tail, r_x;
    logic r_ne;
    logic [PW-1:0] r_cur, r_prev;
    logic [7:0] r_rdev;
    logic [31:0] r_rblk;
    logic [4:0] r_rflg;
    logic [PW-1:0] r_rbn;
    logic [IW-1:0] r_rfn, r_rfp;
    logic [IW:0] r_ic;
    logic [BW-1:0] r_ob;

    logic [BW-1:0] bk;
    assign bk = BW'(r_cmd.req.block_number % bbcm_pkg::BUCKET_COUNT);
    logic [BW-1:0] obk;
    assign obk = BW'(r_rblk % bbcm_pkg::BUCKET_COUNT);

    assign o_cready = (r_st == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_ic <= '0;
            o_valid <= 1'b0;
            r_head <= '0;
            r_tail <= IW'(bbcm_pkg::BUFFER_COUNT - 1);
            r_ne <= 1'b1;
            for (int b = 0; b < bbcm_pkg::BUCKET_COUNT; b++) r_bh[b] <= (b == 0) ? '0 : NIL;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                S_INIT: begin
                    m_dev[r_ic[IW-1:0]] <= '0;
                    m_blk[r_ic[IW-1:0]] <= '0;
                    m_flg[r_ic[IW-1:0]] <= '0;
                    m_fn[r_ic[IW-1:0]] <= r_ic[IW-1:0] + 1'b1;
                    m_fp[r_ic[IW-1:0]] <= (r_ic == '0) ? '0 : r_ic[IW-1:0] - 1'b1;
                    m_bn[r_ic[IW-1:0]] <= PW'(r_ic) + 1'b1;
                    r_ic <= r_ic + 1'b1;
                    if (r_ic == (IW+1)'(bbcm_pkg::BUFFER_COUNT - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cvalid && !o_valid) begin
                        r_cmd <= i_cmd;
                        o_data <= '{bbcm_pkg::ST_ERROR, 10'd0, 1'b0};
                        if (i_cmd.req.kind == bbcm_pkg::K_GET) begin
                            r_cur <= r_bh[BW'(i_cmd.req.block_number
                                % bbcm_pkg::BUCKET_COUNT)];
                            r_st <= S_WALK;
                        end else if (i_cmd.idx_ok) begin
                            r_x <= i_cmd.req.buffer_index[IW-1:0];
                            r_st <= S_FRD;
                        end else r_st <= S_OUT;
                    end
                end
                S_FRD: begin
                    r_rflg <= m_flg[r_x];
                    r_st <= S_FOP;
                end
                S_FOP: begin
                    r_st <= S_OUT;
                    unique case (r_cmd.req.kind)
                        bbcm_pkg::K_DONE: if (!r_rflg[2]) begin
                            m_flg[r_x] <= {r_rflg[4], r_cmd.req.io_failed, 1'b1, r_rflg[1:0]};
                            o_data.status <= bbcm_pkg::ST_ACCEPT;
                        end
                        bbcm_pkg::K_REL: if (r_rflg[0]) begin
                            m_flg[r_x] <= {r_rflg[4:2], r_rflg[1] | r_rflg[3], 1'b0};
                            o_data.status <= bbcm_pkg::ST_ACCEPT;
                            if (!r_ne) begin
                                r_head <= r_x;
                                r_tail <= r_x;
                                r_ne <= 1'b1;
                            end else if (r_rflg[1] | r_rflg[3]) begin
                                m_fn[r_x] <= r_head;
                                m_fp[r_head] <= r_x;
                                r_head <= r_x;
                            end else begin
                                m_fp[r_x] <= r_tail;
                                m_fn[r_tail] <= r_x;
                                r_tail <= r_x;
                            end
                        end
                        bbcm_pkg::K_REARM: if (r_rflg[0]) begin
                            m_flg[r_x] <= {r_rflg[4], 2'b00, r_rflg[1:0]};
                            o_data.status <= bbcm_pkg::ST_ACCEPT;
                        end
                        default: ;
                    endcase
                end
                S_WALK: begin
                    if (r_cur == NIL) begin
                        if (!r_ne) begin
                            o_data.status <= bbcm_pkg::ST_NONE;
                            r_st <= S_OUT;
                        end else begin
                            r_x <= r_head;
                            r_st <= S_MISS;
                        end
                    end else begin
                        r_rdev <= m_dev[r_cur[IW-1:0]];
                        r_rblk <= m_blk[r_cur[IW-1:0]];
                        r_rflg <= m_flg[r_cur[IW-1:0]];
                        r_rbn <= m_bn[r_cur[IW-1:0]];
                        r_st <= S_WCHK;
                    end
                end
                S_WCHK: begin
                    if (r_rflg[4] && !r_rflg[1] && r_rdev == r_cmd.req.device_id
                        && r_rblk == r_cmd.req.block_number) begin
                        r_x <= r_cur[IW-1:0];
                        if (r_rflg[0]) begin
                            o_data.status <= bbcm_pkg::ST_BUSY;
                            r_st <= S_OUT;
                        end else begin
                            o_data <= '{bbcm_pkg::ST_HIT, 10'(r_cur[IW-1:0]), ~r_rflg[2]};
                            m_flg[r_cur[IW-1:0]] <= r_rflg | 5'b00001;
                            r_st <= S_RM;
                        end
                    end else begin
                        r_cur <= r_rbn;
                        r_st <= S_WALK;
                    end
                end
                S_MISS: begin
                    o_data <= '{bbcm_pkg::ST_MISS, 10'(r_x), 1'b1};
                    r_rblk <= m_blk[r_x];
                    r_st <= S_RM;
                end
                S_RM: begin
                    r_rfn <= m_fn[r_x];
                    r_rfp <= m_fp[r_x];
                    r_st <= S_RM2;
                end
                S_RM2: begin
                    if (r_head == r_x && r_tail == r_x) r_ne <= 1'b0;
                    else if (r_head == r_x) r_head <= r_rfn;
                    else if (r_tail == r_x) r_tail <= r_rfp;
                    else begin
                        m_fn[r_rfp] <= r_rfn;
                        m_fp[r_rfn] <= r_rfp;
                    end
                    r_st <= (o_data.status == bbcm_pkg::ST_MISS) ? S_BR : S_OUT;
                end
                S_BR: begin
                    r_ob <= obk;
                    r_cur <= r_bh[obk];
                    r_prev <= NIL;
                    r_st <= S_BRC;
                end
                S_BRC: begin
                    if (r_cur == NIL) r_st <= S_BINS;
                    else begin
                        r_rbn <= m_bn[r_cur[IW-1:0]];
                        r_st <= S_BRN;
                    end
                end
                S_BRN: begin
                    if (r_cur[IW-1:0] == r_x) begin
                        if (r_prev == NIL) r_bh[r_ob] <= r_rbn;
                        else m_bn[r_prev[IW-1:0]] <= r_rbn;
                        r_st <= S_BINS;
                    end else begin
                        r_prev <= r_cur;
                        r_cur <= r_rbn;
                        r_st <= S_BRC;
                    end
                end
                S_BINS: begin
                    m_dev[r_x] <= r_cmd.req.device_id;
                    m_blk[r_x] <= r_cmd.req.block_number;
                    m_flg[r_x] <= 5'b10001;
                    m_bn[r_x] <= r_bh[bk];
                    r_bh[bk] <= PW'(r_x);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/block_buffer_cache_manager.sv]
// Complete/release/rearm read and update the buffer's flags; a get walks its bucket chain
// and, on a miss, takes the free-list head and moves it from its old bucket's chain to the
// new one. One item at a time in the back end; it takes no new command until the result
// beat has been taken.
// Reset: synchronous; a pass clearing all buffers follows, only two beats queue meanwhile.
// Depends on bbcm_pkg, bbcm_front, bbcm_back.
module block_buffer_cache_manager (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bbcm_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output bbcm_pkg::t_out o_data
);
    logic cv, cr;
    bbcm_pkg::t_cmd cmd;
    bbcm_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_cvalid(cv), .i_cready(cr), .o_cmd(cmd));
    bbcm_back u_back (.i_clk, .i_rst_n, .i_cvalid(cv), .o_cready(cr), .i_cmd(cmd),
        .o_valid, .i_ready, .o_data);
endmodule

[hdl/bbcm_checker.sv]
// Port-level checker for the block buffer cache manager, bound to the top.
// Depends on bbcm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bbcm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input bbcm_pkg::t_out o_data
);
    `CHK_IMPL(a_status_range, i_clk, i_rst_n, o_valid, o_data.status <= bbcm_pkg::ST_ERROR)
    `CHK_IMPL(a_miss_reads, i_clk, i_rst_n, o_valid && o_data.status == bbcm_pkg::ST_MISS, o_data.needs_read)
    `CHK_IMPL(a_nogrant_zero, i_clk, i_rst_n, o_valid && o_data.status > bbcm_pkg::ST_MISS, o_data.granted_index == 10'd0 && !o_data.needs_read)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
endmodule
bind block_buffer_cache_manager bbcm_checker u_chk (.i_clk, .i_rst_n, .o_valid, .i_ready, .o_data);

[tb/tb.sv]
// Self-checking testbench for block_buffer_cache_manager: gets, completions, releases, rearms.
// A tag scoreboard class predicts every response; depends on bbcm_pkg and the block RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NIL = bbcm_pkg::BUFFER_COUNT;
    localparam int NB = bbcm_pkg::BUCKET_COUNT;

    class tag_scoreboard;
        logic [7:0]  dev_tag[NIL];
        logic [31:0] blk_tag[NIL];
        bit busy[NIL];
        bit inval[NIL];
        bit done[NIL];
        bit failed[NIL];
        bit bound[NIL];
        int lru_next[NIL];
        int lru_prev[NIL];
        int lru_head, lru_tail;
        bit lru_nonempty;
        int chain_next[NIL];
        int chain_head[NB];
        bbcm_pkg::t_out resp_q[$];
        int mismatches;

        function new();
            for (int i = 0; i < NIL; i++) begin
                dev_tag[i] = '0; blk_tag[i] = '0;
                busy[i] = 0; inval[i] = 0; done[i] = 0; failed[i] = 0; bound[i] = 0;
                lru_next[i] = (i + 1 < NIL) ? i + 1 : 0;
                lru_prev[i] = (i > 0) ? i - 1 : 0;
                chain_next[i] = i + 1;
            end
            lru_head = 0;
            lru_tail = NIL - 1;
            lru_nonempty = 1;
            for (int b = 0; b < NB; b++) chain_head[b] = NIL;
            chain_head[0] = 0;
            mismatches = 0;
        endfunction

        function int bucket_of(logic [31:0] blk);
            return int'(blk % NB);
        endfunction

        function void lru_take(int i);
            if (!lru_nonempty) return;
            if (lru_head == i && lru_tail == i) begin
                lru_nonempty = 0;
            end else if (lru_head == i) begin
                lru_head = lru_next[i];
            end else if (lru_tail == i) begin
                lru_tail = lru_prev[i];
            end else begin
                lru_next[lru_prev[i]] = lru_next[i];
                lru_prev[lru_next[i]] = lru_prev[i];
            end
        endfunction

        function void lru_put(int i, bit at_front);
            if (!lru_nonempty) begin
                lru_head = i; lru_tail = i; lru_nonempty = 1;
            end else if (at_front) begin
                lru_next[i] = lru_head; lru_prev[lru_head] = i; lru_head = i;
            end else begin
                lru_prev[i] = lru_tail; lru_next[lru_tail] = i; lru_tail = i;
            end
        endfunction

        function void chain_unlink(int i);
            int b, cur, prv;
            b = bucket_of(blk_tag[i]);
            cur = chain_head[b];
            prv = NIL;
            for (int s = 0; s < NIL && cur < NIL; s++) begin
                if (cur == i) begin
                    if (prv == NIL) chain_head[b] = chain_next[cur];
                    else chain_next[prv] = chain_next[cur];
                    return;
                end
                prv = cur;
                cur = chain_next[cur];
            end
        endfunction

        function int find(logic [7:0] dv, logic [31:0] blk);
            int cur;
            cur = chain_head[bucket_of(blk)];
            for (int s = 0; s < NIL && cur < NIL; s++) begin
                if (bound[cur] && !inval[cur] && dev_tag[cur] == dv && blk_tag[cur] == blk)
                    return cur;
                cur = chain_next[cur];
            end
            return NIL;
        endfunction

        function int pick_busy();
            int start, j;
            start = $urandom_range(NIL - 1);
            for (int k = 0; k < NIL; k++) begin
                j = (start + k) % NIL;
                if (busy[j]) return j;
            end
            return -1;
        endfunction

        function void note_beat(bbcm_pkg::t_in x);
            bbcm_pkg::t_out r;
            int h, v, b, idx;
            r = '0;
            r.status = bbcm_pkg::ST_ERROR;
            idx = int'(x.buffer_index);
            if (x.kind == bbcm_pkg::K_GET) begin
                h = find(x.device_id, x.block_number);
                if (h < NIL) begin
                    if (busy[h]) begin
                        r.status = bbcm_pkg::ST_BUSY;
                    end else begin
                        lru_take(h);
                        busy[h] = 1;
                        r.status = bbcm_pkg::ST_HIT;
                        r.granted_index = h[9:0];
                        r.needs_read = !done[h];
                    end
                end else if (!lru_nonempty) begin
                    r.status = bbcm_pkg::ST_NONE;
                end else begin
                    v = lru_head;
                    lru_take(v);
                    chain_unlink(v);
                    dev_tag[v] = x.device_id;
                    blk_tag[v] = x.block_number;
                    busy[v] = 1; bound[v] = 1; inval[v] = 0; done[v] = 0; failed[v] = 0;
                    b = bucket_of(x.block_number);
                    chain_next[v] = chain_head[b];
                    chain_head[b] = v;
                    r.status = bbcm_pkg::ST_MISS;
                    r.granted_index = v[9:0];
                    r.needs_read = 1'b1;
                end
            end else if (idx < NIL) begin
                if (x.kind == bbcm_pkg::K_DONE) begin
                    if (!done[idx]) begin
                        done[idx] = 1;
                        failed[idx] = x.io_failed;
                        r.status = bbcm_pkg::ST_ACCEPT;
                    end
                end else if (x.kind == bbcm_pkg::K_REL) begin
                    if (busy[idx]) begin
                        if (failed[idx]) inval[idx] = 1;
                        lru_put(idx, inval[idx]);
                        busy[idx] = 0;
                        r.status = bbcm_pkg::ST_ACCEPT;
                    end
                end else begin
                    if (busy[idx]) begin
                        done[idx] = 0;
                        failed[idx] = 0;
                        r.status = bbcm_pkg::ST_ACCEPT;
                    end
                end
            end
            resp_q.insert(resp_q.size(), r);
        endfunction

        function void check_beat(bbcm_pkg::t_out y);
            bbcm_pkg::t_out e;
            if (resp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", y);
                return;
            end
            e = resp_q[0];
            resp_q.delete(0);
            if (y.status !== e.status || y.granted_index !== e.granted_index ||
                y.needs_read !== e.needs_read) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp status %0d idx %0d rd %0d, got %0d %0d %0d",
                             e.status, e.granted_index, e.needs_read,
                             y.status, y.granted_index, y.needs_read);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    bbcm_pkg::t_in  i_data;
    bbcm_pkg::t_out o_data;
    int   idle_in, idle_out;
    logic [31:0] blk_pool[64];
    tag_scoreboard sb;

    block_buffer_cache_manager DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("tb: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_beat(o_data);
        i_ready <= ($urandom_range(99) >= idle_out);
    end

    task automatic send(bbcm_pkg::t_in x);
        int gap;
        if ($urandom_range(99) < idle_in) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= x;
        do @(posedge i_clk); while (!o_ready);
        sb.note_beat(x);
    endtask

    task automatic op(logic [1:0] k, logic [7:0] dv, logic [31:0] blk, int idx, bit fl);
        bbcm_pkg::t_in x;
        x.kind = k;
        x.device_id = dv;
        x.block_number = blk;
        x.buffer_index = idx[9:0];
        x.io_failed = fl;
        send(x);
    endtask

    task automatic random_beat();
        bbcm_pkg::t_in x;
        logic [63:0] raw;
        int sel, b;
        sel = $urandom_range(99);
        b = sb.pick_busy();
        if (sel < 10) begin
            raw = {$urandom, $urandom};
            x = raw[$bits(bbcm_pkg::t_in)-1:0];
            send(x);
        end else if (sel < 50 || b < 0) begin
            op(bbcm_pkg::K_GET, 8'($urandom_range(3)), blk_pool[$urandom_range(63)],
               int'($urandom_range(1023)), 1'($urandom_range(1)));
        end else if (sel < 72) begin
            op(bbcm_pkg::K_DONE, 8'($urandom), $urandom, b, $urandom_range(99) < 25);
        end else if (sel < 93) begin
            op(bbcm_pkg::K_REL, 8'($urandom), $urandom, b, 1'($urandom_range(1)));
        end else begin
            op(bbcm_pkg::K_REARM, 8'($urandom), $urandom, b, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_data = '0;
        idle_in = 0;
        idle_out = 0;
        for (int i = 0; i < 64; i++)
            blk_pool[i] = (i < 40) ? 32'($urandom_range(47)) : $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        op(bbcm_pkg::K_GET, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_REL, 8'd0, 32'd0, 5, 1'b0);
        op(bbcm_pkg::K_DONE, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_DONE, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_GET, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_REARM, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_REARM, 8'd0, 32'd0, 7, 1'b0);
        op(bbcm_pkg::K_DONE, 8'd0, 32'd0, 0, 1'b1);
        op(bbcm_pkg::K_REL, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_GET, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_REL, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_GET, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_DONE, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_REL, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_GET, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_REL, 8'd0, 32'd0, 0, 1'b0);
        op(bbcm_pkg::K_GET, 8'hFF, 32'hFFFF_FFFF, 1023, 1'b1);
        op(bbcm_pkg::K_GET, 8'hFF, 32'hFFFF_FFFF, 1023, 1'b1);
        op(bbcm_pkg::K_DONE, 8'hFF, 32'hFFFF_FFFF, 1023, 1'b1);
        op(bbcm_pkg::K_DONE, 8'hFF, 32'hFFFF_FFFF, 1023, 1'b0);
        op(bbcm_pkg::K_REARM, 8'd0, 32'd0, 1023, 1'b0);
        op(bbcm_pkg::K_REL, 8'd0, 32'd0, 1023, 1'b0);

        idle_in = 17; idle_out = 55;
        repeat (240) random_beat();
        idle_in = 55; idle_out = 17;
        repeat (240) random_beat();
        idle_in = 0; idle_out = 0;
        repeat (240) random_beat();
        i_valid <= 1'b0;

        while (sb.resp_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.resp_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
